// ----- hdl/rag_pkg.sv -----
`default_nettype none
package rag_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TIMER_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  localparam logic [CFG_WIDTH-1:0]   TIME_RESET = CFG_WIDTH'(50);

  typedef enum logic [2:0] {
    KIND_BEGIN     = 3'd0,
    KIND_COMPLETE  = 3'd1,
    KIND_TICK      = 3'd2,
    KIND_CLEAR_DISC = 3'd3,
    KIND_CLEAR_ALL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DRAIN = 2'd1,
    PH_QUIET = 2'd2,
    PH_DISC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_QUIET  = 2'd1,
    ACT_COMMIT = 2'd2
  } action_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_DRAIN_TIME = 2'd0,
    REG_QUIET_TIME = 2'd1
  } reg_idx_t;

  // packed MSB first: status lands in the lowest bits
  typedef struct packed {
    logic        time_left_valid;
    logic [15:0] time_left;
    logic        wake;
    logic        intentional;
    logic [15:0] in_flight;
    phase_t      phase_now;
    logic        cleared;
    action_t     gate_action;
    logic        reopened;
    logic        newly_accepted;
    status_t     status;
  } result_t;

  localparam int RESULT_WIDTH = $bits(result_t);
  localparam int OUT_TDATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;

endpackage
`default_nettype wire

// ----- hdl/rag_core.sv -----
`default_nettype none
module rag_core import rag_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic [2:0]           kind,
  input  wire logic                 accepted_flag,
  input  wire logic [CFG_WIDTH-1:0] drain_time,
  input  wire logic [CFG_WIDTH-1:0] quiet_time,
  output result_t                   result
);

  phase_t                 phase, phase_next;
  logic                   pending, pending_next;
  logic                   armed, armed_next;
  logic [COUNT_WIDTH-1:0] outstanding, outstanding_next;
  logic [TIMER_WIDTH-1:0] drain_elapsed, drain_elapsed_next;
  logic [TIMER_WIDTH-1:0] quiet_elapsed, quiet_elapsed_next;

  logic                   ready_now;
  logic                   ready_next;
  logic [TIMER_WIDTH-1:0] de_inc, qe_inc;

  assign ready_now = pending && armed && (outstanding == '0);
  assign de_inc = (drain_elapsed == TIMER_MAX) ? TIMER_MAX : drain_elapsed + 1'b1;
  assign qe_inc = (quiet_elapsed == TIMER_MAX) ? TIMER_MAX : quiet_elapsed + 1'b1;

  always_comb begin
    phase_next         = phase;
    pending_next       = pending;
    armed_next         = armed;
    outstanding_next   = outstanding;
    drain_elapsed_next = drain_elapsed;
    quiet_elapsed_next = quiet_elapsed;
    result             = '0;
    result.status      = ST_OK;
    result.gate_action = ACT_NONE;
    result.phase_now   = PH_IDLE;

    case (kind)
      KIND_BEGIN: begin
        if (phase == PH_DISC) begin
          result.status = ST_REFUSED;
        end else if (outstanding == COUNT_MAX) begin
          result.status = ST_FULL;
        end else begin
          if (phase == PH_IDLE) begin
            pending_next       = 1'b1;
            armed_next         = 1'b0;
            drain_elapsed_next = '0;
            quiet_elapsed_next = '0;
            phase_next         = PH_DRAIN;
            result.newly_accepted = 1'b1;
          end else if (phase == PH_QUIET) begin
            phase_next         = PH_DRAIN;
            quiet_elapsed_next = '0;
            result.reopened    = 1'b1;
          end
          outstanding_next = outstanding + 1'b1;
          result.wake      = 1'b1;
        end
      end
      KIND_COMPLETE: begin
        if (outstanding == '0) begin
          result.status = ST_UNDERFLOW;
        end else begin
          outstanding_next   = outstanding - 1'b1;
          drain_elapsed_next = '0;
          if (accepted_flag && pending && phase != PH_DISC) begin
            armed_next = 1'b1;
          end
          result.wake = pending;
        end
      end
      KIND_TICK: begin
        drain_elapsed_next = de_inc;
        quiet_elapsed_next = qe_inc;
        if (phase == PH_DRAIN && ready_now && de_inc >= drain_time) begin
          phase_next         = PH_QUIET;
          quiet_elapsed_next = '0;
          result.gate_action = ACT_QUIET;
        end else if (phase == PH_QUIET && ready_now && qe_inc >= quiet_time) begin
          phase_next         = PH_DISC;
          result.gate_action = ACT_COMMIT;
        end
      end
      KIND_CLEAR_DISC, KIND_CLEAR_ALL: begin
        if (kind == KIND_CLEAR_ALL || phase == PH_DISC) begin
          phase_next         = PH_IDLE;
          pending_next       = 1'b0;
          armed_next         = 1'b0;
          outstanding_next   = '0;
          drain_elapsed_next = '0;
          quiet_elapsed_next = '0;
          result.cleared     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    ready_next = pending_next && armed_next && (outstanding_next == '0);
    if (phase_next == PH_DRAIN && ready_next) begin
      result.time_left_valid = 1'b1;
      result.time_left = (drain_elapsed_next >= drain_time) ? 16'd0 :
                         16'(drain_time - drain_elapsed_next);
    end else if (phase_next == PH_QUIET && ready_next) begin
      result.time_left_valid = 1'b1;
      result.time_left = (quiet_elapsed_next >= quiet_time) ? 16'd0 :
                         16'(quiet_time - quiet_elapsed_next);
    end

    result.phase_now   = phase_next;
    result.in_flight   = 16'(outstanding_next);
    result.intentional = pending_next && (phase_next == PH_DISC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pending       <= 1'b0;
      armed         <= 1'b0;
      outstanding   <= '0;
      drain_elapsed <= '0;
      quiet_elapsed <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      pending       <= pending_next;
      armed         <= armed_next;
      outstanding   <= outstanding_next;
      drain_elapsed <= drain_elapsed_next;
      quiet_elapsed <= quiet_elapsed_next;
    end
  end

  a_pending_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    pending == (phase != PH_IDLE))
    else $error("pending out of step with phase");

  a_armed_needs_pending: assert property (@(posedge clk) disable iff (rst)
    armed |-> pending)
    else $error("armed without pending");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(outstanding) && $stable(drain_elapsed))
    else $error("state moved without a transaction");

  a_tick_keeps_count: assert property (@(posedge clk) disable iff (rst)
    fire && kind == KIND_TICK |=> $stable(outstanding) && $stable(pending))
    else $error("tick changed the in-flight count");

  a_commit_only_from_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && phase_next == PH_DISC && phase != PH_DISC |-> phase == PH_QUIET)
    else $error("disconnect entered from a phase other than quiescing");

endmodule
`default_nettype wire

// ----- hdl/reconnect_admission_gate.sv -----
// A result is presented once its transaction has passed the input register
// and then the result register.
// Throughput: one transaction per cycle unless m_tready stalls the output; the gate state updates in the
// single combinational pass between the two registers.
// Reset (rst, synchronous): gate idle, counters zero, drain_time and
// quiet_time back to 50, both pipeline registers empty.
`default_nettype none
module reconnect_admission_gate import rag_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,   // [0] accepted_flag
  input  wire logic [2:0]                 s_tuser,   // [2:0] kind
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [1:0] status, [2] newly_accepted, [3] reopened, [5:4] gate_action,
  // [6] cleared, [8:7] phase_now, [24:9] in_flight, [25] intentional,
  // [26] wake, [42:27] time_left, [43] time_left_valid
  output logic [OUT_TDATA_WIDTH-1:0]      m_tdata,
  input  wire logic                       wr_en,
  input  wire logic [IDX_WIDTH-1:0]       wr_index,
  input  wire logic [CFG_WIDTH-1:0]       wr_data
);

  logic [CFG_WIDTH-1:0] drain_time;
  logic [CFG_WIDTH-1:0] quiet_time;

  logic       in_valid;
  logic [2:0] in_kind;
  logic       in_acc;
  logic       advance;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_time <= TIME_RESET;
      quiet_time <= TIME_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_DRAIN_TIME: drain_time <= wr_data;
        REG_QUIET_TIME: quiet_time <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_acc  <= s_tdata[0];
    end
  end

  rag_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .kind          (in_kind),
    .accepted_flag (in_acc),
    .drain_time    (drain_time),
    .quiet_time    (quiet_time),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_TDATA_WIDTH'(result);
    end
  end

endmodule
`default_nettype wire
